>>> rtl/frs_pkg.sv
// shared types and constants for the flight phase recovery sequencer
`timescale 1ns / 1ps

package frs_pkg;

	// field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ALT_W   = 20;
	localparam int unsigned SPD_W   = 19;
	localparam int unsigned ACC_W   = 15;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDAT_W  = 20;

	// flight phases
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE      = 3'd0,
		PH_BOOST     = 3'd1,
		PH_COAST     = 3'd2,
		PH_DROGUE    = 3'd3,
		PH_MAIN      = 3'd4,
		PH_TOUCHDOWN = 3'd5
	} phase_t;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_BOOST_ACCEL  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_BOOST_SPEED  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_BOOST_ALT    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_COAST_ALT    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_APOGEE_SPEED = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_APOGEE_ALT   = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_MAIN_ALT     = 3'd6;
	localparam logic [CIDX_W-1:0] CFG_TOUCH_ALT    = 3'd7;

	// threshold reset values
	localparam logic signed [ACC_W-1:0] RST_BOOST_ACCEL  = 15'sd640;
	localparam logic signed [SPD_W-1:0] RST_BOOST_SPEED  = 19'sd6400;
	localparam logic signed [ALT_W-1:0] RST_BOOST_ALT    = 20'sd1600;
	localparam logic signed [ALT_W-1:0] RST_COAST_ALT    = 20'sd12000;
	localparam logic signed [SPD_W-1:0] RST_APOGEE_SPEED = 19'sd128;
	localparam logic signed [ALT_W-1:0] RST_APOGEE_ALT   = 20'sd47200;
	localparam logic signed [ALT_W-1:0] RST_MAIN_ALT     = 20'sd7200;
	localparam logic signed [ALT_W-1:0] RST_TOUCH_ALT    = 20'sd160;

	// 0.1 m/s in Q.8, speed at which the vehicle counts as stationary
	localparam logic signed [SPD_W-1:0] STILL_SPEED = 19'sd26;

	typedef struct packed {
		logic signed [ACC_W-1:0] boost_accel;
		logic signed [SPD_W-1:0] boost_speed;
		logic signed [ALT_W-1:0] boost_alt;
		logic signed [ALT_W-1:0] coast_alt;
		logic signed [SPD_W-1:0] apogee_speed;
		logic signed [ALT_W-1:0] apogee_alt;
		logic signed [ALT_W-1:0] main_alt;
		logic signed [ALT_W-1:0] touch_alt;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]       now_ms;
		logic                    has_alt_speed;
		logic signed [ALT_W-1:0] altitude;
		logic signed [SPD_W-1:0] vert_speed;
		logic                    has_accel;
		logic signed [ACC_W-1:0] vert_accel;
	} tick_t;

	typedef struct packed {
		logic [PHASE_W-1:0] flight_phase;
		logic               eject_a_on;
		logic               eject_c_on;
		logic               cutter_on;
		logic [TIME_W-1:0]  time_since_ignition;
	} result_t;

endpackage

>>> rtl/frs_if.sv
// handshake interfaces for tick, result and configuration beats
`timescale 1ns / 1ps

interface frs_tick_if import frs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [TIME_W-1:0]       now_ms;
	logic                    has_alt_speed;
	logic signed [ALT_W-1:0] altitude;
	logic signed [SPD_W-1:0] vert_speed;
	logic                    has_accel;
	logic signed [ACC_W-1:0] vert_accel;

	modport source (output valid, now_ms, has_alt_speed, altitude, vert_speed,
		has_accel, vert_accel, input ready);
	modport sink (input valid, now_ms, has_alt_speed, altitude, vert_speed,
		has_accel, vert_accel, output ready);
endinterface

interface frs_result_if import frs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PHASE_W-1:0] flight_phase;
	logic               eject_a_on;
	logic               eject_c_on;
	logic               cutter_on;
	logic [TIME_W-1:0]  time_since_ignition;

	modport source (output valid, flight_phase, eject_a_on, eject_c_on, cutter_on,
		time_since_ignition, input ready);
	modport sink (input valid, flight_phase, eject_a_on, eject_c_on, cutter_on,
		time_since_ignition, output ready);
endinterface

interface frs_cfg_if import frs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/flight_phase_recovery_sequencer.sv
// flight phase recovery sequencer: one tick beat in, one result beat out
// a tick passes the input register, then the result register, before its result is valid
// throughput: one tick per cycle, limited only by result back-pressure
// reset: arst_n low clears phase to idle, held samples, ignition and pulse state
// reset also loads the default thresholds; no clearing pass is needed
`timescale 1ns / 1ps

module flight_phase_recovery_sequencer import frs_pkg::*; #(
	parameter int unsigned BURNOUT_MS           = 4400,
	parameter int unsigned APOGEE_TIMEOUT_MS    = 28000,
	parameter int unsigned MAIN_TIMEOUT_MS      = 110000,
	parameter int unsigned TOUCHDOWN_TIMEOUT_MS = 200,
	parameter int unsigned PULSE_MS             = 2000
) (
	input  logic          clk,
	input  logic          arst_n,
	frs_cfg_if.sink       cfg_wr,
	frs_tick_if.sink      tick_in,
	frs_result_if.source  result_out
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    step_en;

	// pipeline advance
	assign adv_s2 = !valid_s2 || result_out.ready;
	assign tick_in.ready = !valid_s1 || adv_s2;
	assign step_en = valid_s1 && adv_s2;

	frs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_in.ready) begin
			valid_s1 <= tick_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) begin
			tick_s1.now_ms <= tick_in.now_ms;
			tick_s1.has_alt_speed <= tick_in.has_alt_speed;
			tick_s1.altitude <= tick_in.altitude;
			tick_s1.vert_speed <= tick_in.vert_speed;
			tick_s1.has_accel <= tick_in.has_accel;
			tick_s1.vert_accel <= tick_in.vert_accel;
		end
	end

	frs_phase_core #(
		.BURNOUT_MS           (BURNOUT_MS),
		.APOGEE_TIMEOUT_MS    (APOGEE_TIMEOUT_MS),
		.MAIN_TIMEOUT_MS      (MAIN_TIMEOUT_MS),
		.TOUCHDOWN_TIMEOUT_MS (TOUCHDOWN_TIMEOUT_MS),
		.PULSE_MS             (PULSE_MS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.cfg    (cfg),
		.tick   (tick_s1),
		.res    (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res_comb;
		end
	end

	// result beat
	assign result_out.valid = valid_s2;
	assign result_out.flight_phase = res_s2.flight_phase;
	assign result_out.eject_a_on = res_s2.eject_a_on;
	assign result_out.eject_c_on = res_s2.eject_c_on;
	assign result_out.cutter_on = res_s2.cutter_on;
	assign result_out.time_since_ignition = res_s2.time_since_ignition;

`ifndef SYNTHESIS
	// both ejection channels always fire together
	a_eject_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.eject_a_on == res_s2.eject_c_on)
		else $error("ejection channels disagree");

	// a stalled result holds while a new tick waits in the input register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_out.ready |=> valid_s2 && $stable(res_s2))
		else $error("pending result overwritten");

	// a processed tick always lands in the result register
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> valid_s2)
		else $error("processed tick lost");
`endif

endmodule

>>> rtl/frs_cfg_regs.sv
// threshold register file written through the configuration channel
`timescale 1ns / 1ps

module frs_cfg_regs import frs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	frs_cfg_if.sink    cfg_wr,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_wr.ready = 1'b1;
	assign cfg = cfg_q;

	// register writes, one per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boost_accel  <= RST_BOOST_ACCEL;
			cfg_q.boost_speed  <= RST_BOOST_SPEED;
			cfg_q.boost_alt    <= RST_BOOST_ALT;
			cfg_q.coast_alt    <= RST_COAST_ALT;
			cfg_q.apogee_speed <= RST_APOGEE_SPEED;
			cfg_q.apogee_alt   <= RST_APOGEE_ALT;
			cfg_q.main_alt     <= RST_MAIN_ALT;
			cfg_q.touch_alt    <= RST_TOUCH_ALT;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				CFG_BOOST_ACCEL:  cfg_q.boost_accel  <= cfg_wr.data[ACC_W-1:0];
				CFG_BOOST_SPEED:  cfg_q.boost_speed  <= cfg_wr.data[SPD_W-1:0];
				CFG_BOOST_ALT:    cfg_q.boost_alt    <= cfg_wr.data[ALT_W-1:0];
				CFG_COAST_ALT:    cfg_q.coast_alt    <= cfg_wr.data[ALT_W-1:0];
				CFG_APOGEE_SPEED: cfg_q.apogee_speed <= cfg_wr.data[SPD_W-1:0];
				CFG_APOGEE_ALT:   cfg_q.apogee_alt   <= cfg_wr.data[ALT_W-1:0];
				CFG_MAIN_ALT:     cfg_q.main_alt     <= cfg_wr.data[ALT_W-1:0];
				CFG_TOUCH_ALT:    cfg_q.touch_alt    <= cfg_wr.data[ALT_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

>>> rtl/frs_phase_core.sv
// flight state, held samples, pulse timing and the per-tick phase rule
`timescale 1ns / 1ps

module frs_phase_core import frs_pkg::*; #(
	parameter int unsigned BURNOUT_MS           = 4400,
	parameter int unsigned APOGEE_TIMEOUT_MS    = 28000,
	parameter int unsigned MAIN_TIMEOUT_MS      = 110000,
	parameter int unsigned TOUCHDOWN_TIMEOUT_MS = 200,
	parameter int unsigned PULSE_MS             = 2000
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  cfg_t    cfg,
	input  tick_t   tick,
	output result_t res
);

	localparam logic [TIME_W-1:0] BURNOUT_T = TIME_W'(BURNOUT_MS);
	localparam logic [TIME_W-1:0] APOGEE_T  = TIME_W'(APOGEE_TIMEOUT_MS);
	localparam logic [TIME_W-1:0] MAIN_T    = TIME_W'(MAIN_TIMEOUT_MS);
	localparam logic [TIME_W-1:0] TOUCH_T   = TIME_W'(TOUCHDOWN_TIMEOUT_MS);
	localparam logic [TIME_W-1:0] PULSE_T   = TIME_W'(PULSE_MS);

	phase_t                  phase_q, phase_d;
	logic [TIME_W-1:0]       ign_q, ign_d;
	logic signed [ALT_W-1:0] alt_q, alt_d;
	logic signed [SPD_W-1:0] spd_q, spd_d;
	logic signed [ACC_W-1:0] acc_q, acc_d;
	logic [TIME_W-1:0]       pend_q, pend_d;
	logic                    drg_q, drg_d;
	logic                    mn_q, mn_d;
	logic [TIME_W-1:0]       elapsed;
	logic [TIME_W-1:0]       remaining;
	logic                    hold_pulse;

	// sample hold and pulse window
	always_comb begin
		alt_d = tick.has_alt_speed ? tick.altitude : alt_q;
		spd_d = tick.has_alt_speed ? tick.vert_speed : spd_q;
		acc_d = tick.has_accel ? tick.vert_accel : acc_q;
		elapsed = tick.now_ms - ign_q;
		remaining = pend_q - tick.now_ms;
		hold_pulse = (drg_q || mn_q) && (remaining != '0) && (remaining <= PULSE_T);
	end

	// phase rule
	always_comb begin
		phase_d = phase_q;
		ign_d = ign_q;
		pend_d = pend_q;
		drg_d = hold_pulse ? drg_q : 1'b0;
		mn_d = hold_pulse ? mn_q : 1'b0;
		if (!hold_pulse) begin
			case (phase_q)
				PH_IDLE: begin
					if (acc_d >= cfg.boost_accel || spd_d >= cfg.boost_speed ||
						alt_d >= cfg.boost_alt) begin
						ign_d = tick.now_ms;
						phase_d = PH_BOOST;
					end
				end
				PH_BOOST: begin
					if (alt_d >= cfg.coast_alt || elapsed >= BURNOUT_T)
						phase_d = PH_COAST;
				end
				PH_COAST: begin
					if (spd_d <= cfg.apogee_speed || alt_d <= cfg.apogee_alt ||
						elapsed >= APOGEE_T) begin
						phase_d = PH_DROGUE;
						drg_d = 1'b1;
						pend_d = tick.now_ms + PULSE_T;
					end
				end
				PH_DROGUE: begin
					if (alt_d <= cfg.main_alt || elapsed >= MAIN_T) begin
						phase_d = PH_MAIN;
						mn_d = 1'b1;
						pend_d = tick.now_ms + PULSE_T;
					end
				end
				PH_MAIN: begin
					if (alt_d <= cfg.touch_alt || spd_d <= STILL_SPEED || elapsed >= TOUCH_T)
						phase_d = PH_TOUCHDOWN;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// result of this tick
	always_comb begin
		res.flight_phase = phase_d;
		res.eject_a_on = drg_d;
		res.eject_c_on = drg_d;
		res.cutter_on = mn_d;
		res.time_since_ignition = elapsed;
	end

	// state update on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ign_q <= '0;
			alt_q <= '0;
			spd_q <= '0;
			acc_q <= '0;
			pend_q <= '0;
			drg_q <= 1'b0;
			mn_q <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			ign_q <= ign_d;
			alt_q <= alt_d;
			spd_q <= spd_d;
			acc_q <= acc_d;
			pend_q <= pend_d;
			drg_q <= drg_d;
			mn_q <= mn_d;
		end
	end

`ifndef SYNTHESIS
	// phase only moves forward
	a_phase_forward: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) |-> phase_q >= $past(phase_q))
		else $error("flight phase moved backward");

	// ejection and cutter pulses never overlap
	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		!(drg_q && mn_q))
		else $error("drogue and main pulses both active");

	// a new drogue pulse only starts on entry to drogue
	a_drogue_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drg_q) |-> phase_q == PH_DROGUE && $past(phase_q) == PH_COAST)
		else $error("drogue pulse started outside drogue entry");

	// ignition time is only taken when leaving idle
	a_ign_capture: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ign_q) |-> $past(phase_q) == PH_IDLE && phase_q == PH_BOOST)
		else $error("ignition time changed outside ignition");
`endif

endmodule

>>> tb/sv/flight_phase_recovery_sequencer_tb.sv
// self-checking testbench for the flight phase recovery sequencer
`timescale 1ns / 1ps

module flight_phase_recovery_sequencer_tb;
	import frs_pkg::*;

	localparam logic [TIME_W-1:0] BURNOUT_MS           = 32'd4400;
	localparam logic [TIME_W-1:0] APOGEE_TIMEOUT_MS    = 32'd28000;
	localparam logic [TIME_W-1:0] MAIN_TIMEOUT_MS      = 32'd110000;
	localparam logic [TIME_W-1:0] TOUCHDOWN_TIMEOUT_MS = 32'd200;
	localparam logic [TIME_W-1:0] PULSE_MS             = 32'd2000;
	localparam int unsigned       SETTLE_CYCLES        = 8;

	// one directed tick, with an optional hand-written expectation
	typedef struct {
		tick_t   stim;
		bit      typed;
		result_t want;
	} drill_row_t;

	logic clk;
	logic arst_n;

	frs_cfg_if    cfg_bus ();
	frs_tick_if   tick_bus ();
	frs_result_if result_bus ();

	flight_phase_recovery_sequencer #(
		.BURNOUT_MS           (BURNOUT_MS),
		.APOGEE_TIMEOUT_MS    (APOGEE_TIMEOUT_MS),
		.MAIN_TIMEOUT_MS      (MAIN_TIMEOUT_MS),
		.TOUCHDOWN_TIMEOUT_MS (TOUCHDOWN_TIMEOUT_MS),
		.PULSE_MS             (PULSE_MS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_bus),
		.tick_in    (tick_bus),
		.result_out (result_bus)
	);

	// flight state mirrored by the bench
	cfg_t                    thr;
	phase_t                  fl_phase;
	logic [TIME_W-1:0]       ign_ms;
	logic [TIME_W-1:0]       pulse_end_ms;
	logic signed [ALT_W-1:0] hold_alt;
	logic signed [SPD_W-1:0] hold_spd;
	logic signed [ACC_W-1:0] hold_acc;
	bit                      drogue_on;
	bit                      main_on;

	result_t           due_outputs[$];
	result_t           want;
	drill_row_t        drill_rows[$];
	int unsigned       mismatch_count;
	int unsigned       tx_idle_pct;
	int unsigned       rx_stall_pct;
	int unsigned       rx_hold;
	logic [TIME_W-1:0] clock_ms;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(input int unsigned busy_pct);
		if ($urandom_range(0, 99) >= busy_pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag_mismatch(input string what, input logic [TIME_W-1:0] got,
		input logic [TIME_W-1:0] wanted);
		mismatch_count++;
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, wanted);
	endtask

	// threshold register update, narrow registers keep their low bits only
	task automatic note_threshold(input logic [CIDX_W-1:0] idx,
		input logic [CDAT_W-1:0] data);
		case (idx)
			CFG_BOOST_ACCEL:  thr.boost_accel  = data[ACC_W-1:0];
			CFG_BOOST_SPEED:  thr.boost_speed  = data[SPD_W-1:0];
			CFG_BOOST_ALT:    thr.boost_alt    = data[ALT_W-1:0];
			CFG_COAST_ALT:    thr.coast_alt    = data[ALT_W-1:0];
			CFG_APOGEE_SPEED: thr.apogee_speed = data[SPD_W-1:0];
			CFG_APOGEE_ALT:   thr.apogee_alt   = data[ALT_W-1:0];
			CFG_MAIN_ALT:     thr.main_alt     = data[ALT_W-1:0];
			CFG_TOUCH_ALT:    thr.touch_alt    = data[ALT_W-1:0];
			default: ;
		endcase
	endtask

	// one control tick through the phase rules
	task automatic advance_flight(input tick_t t, output result_t r);
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] left;
		bit                run_rule;
		if (t.has_alt_speed) begin
			hold_alt = t.altitude;
			hold_spd = t.vert_speed;
		end
		if (t.has_accel)
			hold_acc = t.vert_accel;
		// measured before any rule, so the ignition tick still sees the old time
		elapsed  = t.now_ms - ign_ms;
		run_rule = 1'b1;
		// a running pulse blocks the rules; any tick outside its window ends it
		if (drogue_on || main_on) begin
			left = pulse_end_ms - t.now_ms;
			if (left != 0 && left <= PULSE_MS) begin
				run_rule = 1'b0;
			end else begin
				drogue_on = 1'b0;
				main_on   = 1'b0;
			end
		end
		if (run_rule) begin
			case (fl_phase)
				PH_IDLE: begin
					if ($signed(hold_acc) >= $signed(thr.boost_accel) ||
						$signed(hold_spd) >= $signed(thr.boost_speed) ||
						$signed(hold_alt) >= $signed(thr.boost_alt)) begin
						ign_ms   = t.now_ms;
						fl_phase = PH_BOOST;
					end
				end
				PH_BOOST: begin
					if ($signed(hold_alt) >= $signed(thr.coast_alt) || elapsed >= BURNOUT_MS)
						fl_phase = PH_COAST;
				end
				PH_COAST: begin
					if ($signed(hold_spd) <= $signed(thr.apogee_speed) ||
						$signed(hold_alt) <= $signed(thr.apogee_alt) ||
						elapsed >= APOGEE_TIMEOUT_MS) begin
						fl_phase     = PH_DROGUE;
						drogue_on    = 1'b1;
						pulse_end_ms = t.now_ms + PULSE_MS;
					end
				end
				PH_DROGUE: begin
					if ($signed(hold_alt) <= $signed(thr.main_alt) ||
						elapsed >= MAIN_TIMEOUT_MS) begin
						fl_phase     = PH_MAIN;
						main_on      = 1'b1;
						pulse_end_ms = t.now_ms + PULSE_MS;
					end
				end
				PH_MAIN: begin
					if ($signed(hold_alt) <= $signed(thr.touch_alt) ||
						$signed(hold_spd) <= $signed(STILL_SPEED) ||
						elapsed >= TOUCHDOWN_TIMEOUT_MS)
						fl_phase = PH_TOUCHDOWN;
				end
				default: ;
			endcase
		end
		r.flight_phase        = fl_phase;
		r.eject_a_on          = drogue_on;
		r.eject_c_on          = drogue_on;
		r.cutter_on           = main_on;
		r.time_since_ignition = elapsed;
	endtask

	// directed row; typed rows run up to and including the ignition tick, so time since ignition is now
	function automatic drill_row_t drill(input logic [TIME_W-1:0] now, input bit fresh_as,
		input int alt, input int spd, input bit fresh_acc, input int acc,
		input bit typed, input phase_t ph);
		drill_row_t row;
		row.stim.now_ms             = now;
		row.stim.has_alt_speed      = fresh_as;
		row.stim.altitude           = ALT_W'(alt);
		row.stim.vert_speed         = SPD_W'(spd);
		row.stim.has_accel          = fresh_acc;
		row.stim.vert_accel         = ACC_W'(acc);
		row.typed                   = typed;
		row.want.flight_phase       = ph;
		row.want.eject_a_on         = 1'b0;
		row.want.eject_c_on         = 1'b0;
		row.want.cutter_on          = 1'b0;
		row.want.time_since_ignition = now;
		return row;
	endfunction

	function automatic tick_t random_tick(input logic [TIME_W-1:0] now);
		tick_t t;
		t.now_ms        = now;
		t.has_alt_speed = $urandom_range(0, 1);
		t.altitude      = ALT_W'($urandom);
		t.vert_speed    = SPD_W'($urandom);
		t.has_accel     = $urandom_range(0, 1);
		t.vert_accel    = ACC_W'($urandom);
		return t;
	endfunction

	// one tick beat; valid stays high when the next beat follows at once
	task automatic send_tick(input tick_t t, input bit typed, input result_t typed_want);
		int unsigned gap;
		result_t     predicted;
		gap = pick_gap(tx_idle_pct);
		if (gap != 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_bus.valid         <= 1'b1;
		tick_bus.now_ms        <= t.now_ms;
		tick_bus.has_alt_speed <= t.has_alt_speed;
		tick_bus.altitude      <= t.altitude;
		tick_bus.vert_speed    <= t.vert_speed;
		tick_bus.has_accel     <= t.has_accel;
		tick_bus.vert_accel    <= t.vert_accel;
		do
			@(posedge clk);
		while (!tick_bus.ready);
		advance_flight(t, predicted);
		due_outputs.push_back(typed ? typed_want : predicted);
	endtask

	// config beat; the caller lowers valid after the last one
	task automatic write_threshold(input logic [CIDX_W-1:0] idx, input int value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= CDAT_W'(value);
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		note_threshold(idx, CDAT_W'(value));
	endtask

	// stop ticks and wait until every result is back and the block has settled
	task automatic drain_results();
		tick_bus.valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random ticks with a mostly forward-moving clock, occasional jumps (back ones if enabled) or random times
	task automatic fly_leg(input int unsigned count, input int unsigned max_step,
		input int unsigned jump_pct, input bit back_jumps);
		repeat (count) begin
			if (jump_pct >= 100) begin
				clock_ms = $urandom;
			end else if ($urandom_range(0, 99) < jump_pct) begin
				if (back_jumps && $urandom_range(0, 1))
					clock_ms = clock_ms - $urandom_range(1, 4 * PULSE_MS);
				else
					clock_ms = clock_ms + $urandom_range(PULSE_MS + 1, 4 * PULSE_MS);
			end else begin
				clock_ms = clock_ms + $urandom_range(0, max_step);
			end
			send_tick(random_tick(clock_ms), 1'b0, '0);
		end
	endtask

	// result sink with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold != 0) begin
			result_bus.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			result_bus.ready <= 1'b1;
			rx_hold <= pick_gap(rx_stall_pct);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (due_outputs.size() == 0) begin
				flag_mismatch("unexpected beat", '0, '0);
			end else begin
				want = due_outputs.pop_front();
				if (result_bus.flight_phase !== want.flight_phase)
					flag_mismatch("flight_phase", TIME_W'(result_bus.flight_phase),
						TIME_W'(want.flight_phase));
				if (result_bus.eject_a_on !== want.eject_a_on)
					flag_mismatch("eject_a_on", TIME_W'(result_bus.eject_a_on),
						TIME_W'(want.eject_a_on));
				if (result_bus.eject_c_on !== want.eject_c_on)
					flag_mismatch("eject_c_on", TIME_W'(result_bus.eject_c_on),
						TIME_W'(want.eject_c_on));
				if (result_bus.cutter_on !== want.cutter_on)
					flag_mismatch("cutter_on", TIME_W'(result_bus.cutter_on),
						TIME_W'(want.cutter_on));
				if (result_bus.time_since_ignition !== want.time_since_ignition)
					flag_mismatch("time_since_ignition", result_bus.time_since_ignition,
						want.time_since_ignition);
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("flight_phase_recovery_sequencer_tb: FAIL");
		$finish;
	end

	// stimulus
	initial begin
		arst_n                 = 1'b0;
		tick_bus.valid         = 1'b0;
		tick_bus.now_ms        = '0;
		tick_bus.has_alt_speed = 1'b0;
		tick_bus.altitude      = '0;
		tick_bus.vert_speed    = '0;
		tick_bus.has_accel     = 1'b0;
		tick_bus.vert_accel    = '0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.index          = '0;
		cfg_bus.data           = '0;
		tx_idle_pct            = 0;
		rx_stall_pct           = 0;
		mismatch_count         = 0;
		clock_ms               = '0;

		thr.boost_accel  = RST_BOOST_ACCEL;
		thr.boost_speed  = RST_BOOST_SPEED;
		thr.boost_alt    = RST_BOOST_ALT;
		thr.coast_alt    = RST_COAST_ALT;
		thr.apogee_speed = RST_APOGEE_SPEED;
		thr.apogee_alt   = RST_APOGEE_ALT;
		thr.main_alt     = RST_MAIN_ALT;
		thr.touch_alt    = RST_TOUCH_ALT;
		fl_phase         = PH_IDLE;
		ign_ms           = '0;
		pulse_end_ms     = '0;
		hold_alt         = '0;
		hold_spd         = '0;
		hold_acc         = '0;
		drogue_on        = 1'b0;
		main_on          = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// idle at the time and sample extremes, default thresholds
		drill_rows.push_back(drill(32'd0, 1'b0, 0, 0, 1'b0, 0, 1'b1, PH_IDLE));
		drill_rows.push_back(drill(32'hFFFF_FFFF, 1'b1, -524288, -262144, 1'b1, -16384,
			1'b1, PH_IDLE));
		// stale maxima on the bus must not be latched
		drill_rows.push_back(drill(32'd100, 1'b0, 524287, 262143, 1'b0, 16383, 1'b1, PH_IDLE));
		// one below each ignition threshold
		drill_rows.push_back(drill(32'd200, 1'b1, 1599, 6399, 1'b1, 639, 1'b1, PH_IDLE));
		// ignition on acceleration exactly at threshold, elapsed from the old time
		drill_rows.push_back(drill(32'd1000, 1'b0, 0, 0, 1'b1, 640, 1'b1, PH_BOOST));
		// boost just below the burnout altitude, then burnout on time
		drill_rows.push_back(drill(32'd1001, 1'b1, 11999, 6400, 1'b1, -1, 1'b0, PH_BOOST));
		drill_rows.push_back(drill(32'd5399, 1'b0, 0, 0, 1'b0, 0, 1'b0, PH_BOOST));
		drill_rows.push_back(drill(32'd5400, 1'b0, 0, 0, 1'b0, 0, 1'b0, PH_COAST));
		// coast one step above both apogee thresholds, then on held samples
		drill_rows.push_back(drill(32'd5500, 1'b1, 47201, 129, 1'b0, 0, 1'b0, PH_COAST));
		drill_rows.push_back(drill(32'd5600, 1'b0, -1, -1, 1'b1, 16383, 1'b0, PH_COAST));

		tx_idle_pct  = 25;
		rx_stall_pct = 25;
		foreach (drill_rows[i])
			send_tick(drill_rows[i].stim, drill_rows[i].typed, drill_rows[i].want);
		clock_ms = drill_rows[drill_rows.size() - 1].stim.now_ms;

		// coast with apogee out of reach, thresholds at the extremes
		drain_results();
		write_threshold(CFG_BOOST_ACCEL, 16383);
		write_threshold(CFG_BOOST_SPEED, -262144);
		write_threshold(CFG_BOOST_ALT, 524287);
		write_threshold(CFG_COAST_ALT, 524287);
		write_threshold(CFG_APOGEE_SPEED, -262144);
		write_threshold(CFG_APOGEE_ALT, -524288);
		cfg_bus.valid <= 1'b0;
		tx_idle_pct  = 30;
		rx_stall_pct = 30;
		fly_leg(80, 40, 0, 1'b0);

		// apogee reachable, main out of reach: drogue pulse runs and ends
		drain_results();
		write_threshold(CFG_APOGEE_SPEED, 128);
		write_threshold(CFG_APOGEE_ALT, 47200);
		write_threshold(CFG_MAIN_ALT, -524288);
		cfg_bus.valid <= 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		fly_leg(100, 120, 2, 1'b0);

		// main on any altitude, cutter pulse ends by stepping or a jump either way
		drain_results();
		write_threshold(CFG_MAIN_ALT, 524287);
		write_threshold(CFG_TOUCH_ALT, -524288);
		cfg_bus.valid <= 1'b0;
		tx_idle_pct  = 50;
		rx_stall_pct = 50;
		fly_leg(40, 120, 5, 1'b1);

		// touchdown holds; random registers with junk in the unused high bits
		drain_results();
		write_threshold(CFG_BOOST_ACCEL, $urandom);
		write_threshold(CFG_BOOST_SPEED, $urandom);
		write_threshold(CFG_BOOST_ALT, $urandom);
		write_threshold(CFG_COAST_ALT, $urandom);
		write_threshold(CFG_APOGEE_SPEED, $urandom);
		write_threshold(CFG_APOGEE_ALT, $urandom);
		write_threshold(CFG_MAIN_ALT, $urandom);
		write_threshold(CFG_TOUCH_ALT, $urandom);
		cfg_bus.valid <= 1'b0;
		tx_idle_pct  = 20;
		rx_stall_pct = 60;
		fly_leg(180, 0, 100, 1'b0);

		drain_results();
		if (mismatch_count == 0)
			$display("flight_phase_recovery_sequencer_tb: PASS");
		else
			$display("flight_phase_recovery_sequencer_tb: FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/frs_pkg.sv
rtl/frs_if.sv
rtl/frs_cfg_regs.sv
rtl/frs_phase_core.sv
rtl/flight_phase_recovery_sequencer.sv
tb/sv/flight_phase_recovery_sequencer_tb.sv
